// ----- hw/rtl/sfrsc_pkg.sv -----
// Shared types and constants for the serial frame receiver with sum check.
package sfrsc_pkg;

  localparam logic [7:0] START_BYTE = 8'h40;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SUM_BAD   = 2'd1,
    ST_START_BAD = 2'd2,
    ST_TIMEOUT   = 2'd3
  } status_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic {
    KIND_PAYLOAD   = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      kind;
    status_t    status;
  } result_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

endpackage

// ----- hw/rtl/serial_frame_receiver_sum_check_top.sv -----
// Top level of the serial frame receiver with sum check.
// Requests are registered at the input; results wait in the two-entry result buffer.
// Throughput: one request per cycle while the buffer has room; it absorbs output stalls.
// Input ready depends only on registered state, never combinationally on out_ready.
// Synchronous active-high reset returns the receiver to idle, clears all buffered results
// and sets the timeout register to 1000 ticks.
module serial_frame_receiver_sum_check_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        kind,
  output logic [1:0]  status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import sfrsc_pkg::*;

  logic    res_room;
  logic    res_valid;
  result_t res;
  result_t out_res;

  sfrsc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .rx_byte     (rx_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_room    (res_room),
    .res_valid   (res_valid),
    .res         (res)
  );

  sfrsc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_valid  (res_valid),
    .wr_data   (res),
    .room      (res_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rd_data   (out_res)
  );

  assign data_byte = out_res.data_byte;
  assign kind      = out_res.kind;
  assign status    = out_res.status;

`ifndef SYNTHESIS
  a_payload_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_PAYLOAD) |-> (status == ST_OK))
    else $error("payload result carries a nonzero status");

  a_frame_end_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_FRAME_END) |-> (data_byte == 8'd0))
    else $error("frame end result carries a nonzero data byte");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("receiver not empty and ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({data_byte, kind, status}))
    else $error("waiting result dropped or changed before acceptance");
`endif

endmodule

// ----- hw/rtl/sfrsc_core.sv -----
// Input register, frame state machine and result formation.
module sfrsc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_wr_en,
  input  logic [15:0]           cfg_wr_data,
  input  logic                  res_room,
  output logic                  res_valid,
  output sfrsc_pkg::result_t    res
);
  import sfrsc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY
  } phase_t;

  logic        inq_valid;
  logic        inq_action;
  logic [7:0]  inq_byte;
  logic [15:0] timeout_ticks;

  phase_t      phase;
  phase_t      phase_next;
  logic        start_ok;
  logic        start_ok_next;
  logic [7:0]  length_low;
  logic [7:0]  length_low_next;
  logic [15:0] bytes_left;
  logic [15:0] bytes_left_next;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;
  logic [15:0] idle_count;
  logic [15:0] idle_count_next;
  logic        fire;
  logic [15:0] body_len;

  assign fire     = inq_valid && res_room;
  assign in_ready = !inq_valid || res_room;
  assign body_len = {inq_byte, length_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      inq_action <= action;
      inq_byte   <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_comb begin
    phase_next       = phase;
    start_ok_next    = start_ok;
    length_low_next  = length_low;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    idle_count_next  = idle_count;
    res_valid        = 1'b0;
    res.data_byte    = 8'd0;
    res.kind         = KIND_FRAME_END;
    res.status       = ST_OK;
    if (inq_action == ACT_TICK) begin
      if (phase != PH_IDLE) begin
        if (idle_count >= timeout_ticks) begin
          phase_next      = PH_IDLE;
          idle_count_next = 16'd0;
          res_valid       = 1'b1;
          res.status      = ST_TIMEOUT;
        end else begin
          idle_count_next = idle_count + 16'd1;
        end
      end
    end else begin
      idle_count_next = 16'd0;
      case (phase)
        PH_IDLE: begin
          start_ok_next = (inq_byte == START_BYTE);
          phase_next    = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          length_low_next = inq_byte;
          phase_next      = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (!start_ok) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.status = ST_START_BAD;
          end else if (body_len == 16'd0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.status = ST_OK;
          end else begin
            bytes_left_next  = body_len;
            running_sum_next = 8'd0;
            phase_next       = PH_BODY;
          end
        end
        PH_BODY: begin
          if (bytes_left[15:1] == 15'd0) begin
            phase_next = PH_IDLE;
            res_valid  = 1'b1;
            res.status = (inq_byte == running_sum) ? ST_OK : ST_SUM_BAD;
          end else begin
            running_sum_next = running_sum + inq_byte;
            bytes_left_next  = bytes_left - 16'd1;
            res_valid        = 1'b1;
            res.data_byte    = inq_byte;
            res.kind         = KIND_PAYLOAD;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    res_valid = res_valid && fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      start_ok    <= 1'b0;
      length_low  <= 8'd0;
      bytes_left  <= 16'd0;
      running_sum <= 8'd0;
      idle_count  <= 16'd0;
    end else if (fire) begin
      phase       <= phase_next;
      start_ok    <= start_ok_next;
      length_low  <= length_low_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      idle_count  <= idle_count_next;
    end
  end

endmodule

// ----- hw/rtl/sfrsc_out_fifo.sv -----
// Two-entry result buffer between the frame logic and the output channel.
module sfrsc_out_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  input  sfrsc_pkg::result_t    wr_data,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfrsc_pkg::result_t    rd_data
);
  import sfrsc_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign room      = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({wr_valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    if (wr_valid) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- bench/frame_result_checker.sv -----
// Checker that predicts and compares every result of the serial frame receiver.
`timescale 1ns / 1ps

module frame_result_checker
  import sfrsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  data_byte,
  input  logic        kind,
  input  logic [1:0]  status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          fail_count,
  output int          outstanding
);

  typedef enum logic [1:0] {
    RX_IDLE   = 2'd0,
    RX_LEN_LO = 2'd1,
    RX_LEN_HI = 2'd2,
    RX_BODY   = 2'd3
  } rx_phase_t;

  rx_phase_t   rx_phase;
  logic        start_seen;
  logic [7:0]  len_low;
  logic [15:0] body_left;
  logic [7:0]  body_sum;
  logic [15:0] idle_ticks;
  logic [15:0] tick_limit;
  result_t     expected_results[$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches = mismatches + 1;
  endtask

  task automatic close_frame(input status_t how);
    rx_phase = RX_IDLE;
    idle_ticks = '0;
    expected_results.push_back('{data_byte: 8'h00, kind: KIND_FRAME_END, status: how});
  endtask

  task automatic advance_frame_state(input action_t act, input logic [7:0] b);
    logic [15:0] body_len;
    if (act == ACT_TICK) begin
      if (rx_phase != RX_IDLE) begin
        if ({1'b0, idle_ticks} + 17'd1 > {1'b0, tick_limit}) begin
          close_frame(ST_TIMEOUT);
        end else begin
          idle_ticks = idle_ticks + 16'd1;
        end
      end
    end else begin
      idle_ticks = '0;
      case (rx_phase)
        RX_IDLE: begin
          start_seen = (b == START_BYTE);
          rx_phase = RX_LEN_LO;
        end
        RX_LEN_LO: begin
          len_low = b;
          rx_phase = RX_LEN_HI;
        end
        RX_LEN_HI: begin
          body_len = {b, len_low};
          if (!start_seen) begin
            close_frame(ST_START_BAD);
          end else if (body_len == 16'd0) begin
            close_frame(ST_OK);
          end else begin
            body_left = body_len;
            body_sum = '0;
            rx_phase = RX_BODY;
          end
        end
        default: begin
          if (body_left <= 16'd1) begin
            close_frame((b == body_sum) ? ST_OK : ST_SUM_BAD);
          end else begin
            body_sum = body_sum + b;
            body_left = body_left - 16'd1;
            expected_results.push_back('{data_byte: b, kind: KIND_PAYLOAD, status: ST_OK});
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      rx_phase = RX_IDLE;
      start_seen = 1'b0;
      len_low = '0;
      body_left = '0;
      body_sum = '0;
      idle_ticks = '0;
      tick_limit = TIMEOUT_RESET;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        tick_limit = cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        advance_frame_state(action_t'(action), rx_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending", 8'h00, data_byte);
        end else begin
          want = expected_results.pop_front();
          if (data_byte !== want.data_byte) begin
            report_mismatch("data_byte", want.data_byte, data_byte);
          end
          if (kind !== want.kind) begin
            report_mismatch("kind", {7'b0, want.kind}, {7'b0, kind});
          end
          if (status !== want.status) begin
            report_mismatch("status", {6'b0, want.status}, {6'b0, status});
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ----- bench/serial_frame_receiver_sum_check_top_test.sv -----
// Stimulus and verdict for the serial frame receiver with sum check.
`timescale 1ns / 1ps

module serial_frame_receiver_sum_check_top_test;
  import sfrsc_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 330;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  action_t     action;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  data_byte;
  logic        kind;
  logic [1:0]  status;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  int          fail_count;
  int          outstanding;

  int item_count = 0;
  int limit_now = TIMEOUT_RESET;
  int stalled_cycles = 0;
  bit long_hold_req = 1'b0;
  bit steady = 1'b0;
  bit sender_gappy = 1'b0;

  serial_frame_receiver_sum_check_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .kind        (kind),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  frame_result_checker result_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_byte   (data_byte),
    .kind        (kind),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_CYCLES) begin
      $display("serial_frame_receiver_sum_check_top_test NOT OK");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    forever begin
      if (long_hold_req && !steady) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input action_t act, input logic [7:0] b, input bit counts);
    in_valid <= 1'b1;
    action <= act;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (counts) begin
      item_count++;
    end
    if (!steady && sender_gappy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_ticks(input int n, input bit counts);
    repeat (n) send_item(ACT_TICK, 8'($urandom_range(0, 255)), counts);
  endtask

  task automatic send_bytes(input logic [255:0] seq, input int n);
    for (int k = 0; k < n; k++) begin
      send_item(ACT_BYTE, seq[8 * (n - 1 - k) +: 8], 1'b1);
    end
  endtask

  function automatic int pick_idle_ticks();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return 0;
    if (roll == 8 || limit_now > 64) return $urandom_range(1, limit_now < 3 ? limit_now : 3);
    return limit_now;
  endfunction

  task automatic send_frame(input logic [7:0] first, input logic [15:0] body_len,
                            input bit sum_good);
    logic [7:0] body_sum;
    logic [7:0] b;
    send_item(ACT_BYTE, first, 1'b1);
    send_ticks(pick_idle_ticks(), 1'b1);
    send_item(ACT_BYTE, body_len[7:0], 1'b1);
    send_ticks(pick_idle_ticks(), 1'b1);
    send_item(ACT_BYTE, body_len[15:8], 1'b1);
    if (first == START_BYTE && body_len != 16'd0) begin
      body_sum = '0;
      for (int i = 1; i < body_len; i++) begin
        send_ticks(pick_idle_ticks(), 1'b1);
        b = 8'($urandom_range(0, 255));
        body_sum = body_sum + b;
        send_item(ACT_BYTE, b, 1'b1);
      end
      send_ticks(pick_idle_ticks(), 1'b1);
      send_item(ACT_BYTE, sum_good ? body_sum : body_sum + 8'($urandom_range(1, 255)), 1'b1);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    wait_quiet();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    limit_now = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phase_start;
    int roll;
    int sel;
    int stage;
    logic [7:0] first;
    logic [15:0] len;
    logic [15:0] next_limit;

    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ACT_BYTE;
    rx_byte <= 8'h00;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 16'h0000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_bytes({8'h40, 8'h02, 8'h00, 8'hAA, 8'hAA}, 5);
    send_bytes({8'h40, 8'h02, 8'h00, 8'h55, 8'h00}, 5);
    send_bytes({8'h40, 8'h00, 8'h00}, 3);
    send_bytes({8'h41, 8'h00, 8'h00}, 3);
    send_bytes({8'h40, 8'h01, 8'h00, 8'h00}, 4);
    send_bytes({8'h40, 8'h01, 8'h00, 8'hFF}, 4);
    send_ticks(2, 1'b0);
    send_bytes({8'h40, 8'h03, 8'h00, 8'h80, 8'h81, 8'h01}, 6);
    // A frame is left open while the limit drops, so the new limit must govern its ticks.
    send_bytes({8'h40, 8'hFF, 8'hFF, 8'h12}, 4);
    write_timeout(16'd1);
    send_ticks(1, 1'b1);
    send_item(ACT_BYTE, 8'h34, 1'b1);
    send_ticks(2, 1'b1);
    send_bytes({8'h40}, 1);
    send_ticks(2, 1'b1);
    send_bytes({8'h40, 8'h05}, 2);
    send_ticks(2, 1'b1);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: next_limit = 16'd1;
        1: next_limit = 16'hFFFF;
        2: next_limit = 16'($urandom_range(2, 24));
        3: next_limit = TIMEOUT_RESET;
        default: next_limit = 16'($urandom_range(25, 64));
      endcase
      write_timeout(next_limit);
      steady = (p == 4);
      if (p == 1) begin
        sender_gappy = 1'b0;
        long_hold_req = 1'b1;
        send_frame(START_BYTE, 16'd60, 1'b1);
        send_frame(START_BYTE, 16'd40, 1'b1);
      end
      phase_start = item_count;
      while (item_count - phase_start < PHASE_ITEMS) begin
        if (p == 2 && item_count - phase_start >= PHASE_ITEMS / 2 &&
            item_count - phase_start < PHASE_ITEMS / 2 + 4) begin
          wait_quiet();
        end
        roll = $urandom_range(0, 99);
        sender_gappy = ($urandom_range(0, 1) == 1);
        if (roll < 70) begin
          sel = $urandom_range(0, 99);
          if (sel == 0) begin
            len = 16'($urandom_range(256, 300));
          end else if (sel < 20) begin
            len = 16'($urandom_range(17, 64));
          end else begin
            len = 16'($urandom_range(1, 16));
          end
          send_frame(START_BYTE, len, $urandom_range(0, 6) != 0);
        end else if (roll < 78 || (roll < 88 && limit_now > 64)) begin
          do first = 8'($urandom_range(0, 255)); while (first == START_BYTE);
          send_frame(first, 16'($urandom_range(0, 65535)), 1'b1);
        end else if (roll < 88) begin
          // Open a frame, stop at a random header or body position, then let it expire.
          stage = $urandom_range(0, 3);
          first = (stage < 2 && $urandom_range(0, 1) == 1) ?
                  8'($urandom_range(0, 255)) : START_BYTE;
          len = 16'($urandom_range(2, 65535));
          send_item(ACT_BYTE, first, 1'b1);
          if (stage >= 1) send_item(ACT_BYTE, len[7:0], 1'b1);
          if (stage >= 2) send_item(ACT_BYTE, len[15:8], 1'b1);
          if (stage == 3) begin
            repeat ($urandom_range(1, len > 16'd6 ? 5 : len - 16'd1)) begin
              send_item(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            end
          end
          send_ticks(limit_now + 1, 1'b1);
        end else if (roll < 94) begin
          send_ticks($urandom_range(1, 5), 1'b0);
        end else begin
          send_frame(START_BYTE, 16'($urandom_range(0, 1)), $urandom_range(0, 1) == 1);
        end
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("serial_frame_receiver_sum_check_top_test OK");
    end else begin
      $display("serial_frame_receiver_sum_check_top_test NOT OK");
    end
    $finish;
  end

endmodule
